// File: rtl/dlts_pkg.sv
`default_nettype none
package dlts_pkg;

  localparam int SLOTS_DEF   = 16;
  localparam int ID_BITS_DEF = 16;

  localparam int CMD_W    = 2;
  localparam int CODE_W   = 8;
  localparam int DELAY_W  = 32;
  localparam int TGT_W    = 16;
  localparam int STATUS_W = 2;
  localparam int AID_W    = 16;

  localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD      = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DISPATCH = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd3;

endpackage
`default_nettype wire

// File: rtl/dlts_mem.sv
`default_nettype none
module dlts_mem #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: rtl/delta_list_task_scheduler.sv
// tick counts down the delay of the head entry unless it is ready; on an empty table it only answers
// delete scans the slots for the target id, then moves every later entry down one slot
// add walks to the insert point, shifts the later entries up one slot, then writes the new entry
// dispatch of a ready head moves the later entries down; a periodic task then takes the insert walk
// one request at a time; in_stall drops as the result is presented
// reset clears control state and the entry count; table memory is not cleared
`default_nettype none
module delta_list_task_scheduler #(
  parameter int Slots  = dlts_pkg::SLOTS_DEF,
  parameter int IdBits = dlts_pkg::ID_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [dlts_pkg::CMD_W-1:0]    command_i,
  input  wire logic [dlts_pkg::CODE_W-1:0]   task_code_i,
  input  wire logic [dlts_pkg::DELAY_W-1:0]  start_delay_i,
  input  wire logic [dlts_pkg::DELAY_W-1:0]  repeat_period_i,
  input  wire logic [dlts_pkg::TGT_W-1:0]    target_id_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [dlts_pkg::STATUS_W-1:0] status_o,
  output logic      [dlts_pkg::AID_W-1:0]    assigned_id_o,
  output logic      [dlts_pkg::CODE_W-1:0]   run_code_o,
  output logic                               run_valid_o
);
  import dlts_pkg::*;

  localparam int IdxW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int CntW = $clog2(Slots + 1);
  localparam int CmpW = (IdBits > TGT_W) ? IdBits : TGT_W;

  typedef struct packed {
    logic               ready;
    logic [CODE_W-1:0]  code;
    logic [DELAY_W-1:0] rel;
    logic [DELAY_W-1:0] period;
    logic [IdBits-1:0]  ident;
  } entry_t;

  localparam int EntW = $bits(entry_t);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_HEAD    = 4'd1;
  localparam logic [3:0] S_INS_RD  = 4'd2;
  localparam logic [3:0] S_INS_CHK = 4'd3;
  localparam logic [3:0] S_UP_RD   = 4'd4;
  localparam logic [3:0] S_UP_WR   = 4'd5;
  localparam logic [3:0] S_INS_PUT = 4'd6;
  localparam logic [3:0] S_INS_NEW = 4'd7;
  localparam logic [3:0] S_DEL_RD  = 4'd8;
  localparam logic [3:0] S_DEL_CHK = 4'd9;
  localparam logic [3:0] S_DN_RD   = 4'd10;
  localparam logic [3:0] S_DN_WR   = 4'd11;
  localparam logic [3:0] S_DONE    = 4'd12;

  logic [3:0]          state_q, state_d;
  logic [CMD_W-1:0]    cmd_q, cmd_d;
  logic [CODE_W-1:0]   code_q, code_d;
  logic [DELAY_W-1:0]  delay_q, delay_d;
  logic [DELAY_W-1:0]  period_q, period_d;
  logic [TGT_W-1:0]    target_q, target_d;
  logic [CntW-1:0]     k_q, k_d;
  logic [CntW-1:0]     j_q, j_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [DELAY_W-1:0]  sum_q, sum_d;
  logic [DELAY_W-1:0]  gap_q, gap_d;
  logic [IdBits-1:0]   id_q, id_d;
  logic                redo_q, redo_d;
  entry_t              cur_q, cur_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [AID_W-1:0]    res_aid_q, res_aid_d;
  logic [CODE_W-1:0]   res_code_q, res_code_d;
  logic                res_run_q, res_run_d;
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q;
  logic [AID_W-1:0]    out_aid_q;
  logic [CODE_W-1:0]   out_code_q;
  logic                out_run_q;

  logic                mem_we, mem_re;
  logic [IdxW-1:0]     mem_waddr, mem_raddr;
  entry_t              mem_wdata, rd_ent;
  logic [EntW-1:0]     mem_rdata;

  logic [DELAY_W:0]    sum_ext;
  logic [DELAY_W-1:0]  new_rel, tick_rel;
  logic [IdBits-1:0]   id_inc, id_next;
  logic                in_acc, out_load;

  assign rd_ent   = entry_t'(mem_rdata);
  assign sum_ext  = {1'b0, sum_q} + {1'b0, rd_ent.rel};
  assign new_rel  = delay_q - sum_q;
  assign tick_rel = (rd_ent.rel != '0) ? rd_ent.rel - 1'b1 : rd_ent.rel;
  assign id_inc   = id_q + 1'b1;
  assign id_next  = (id_inc == '0) ? IdBits'(1) : id_inc;
  assign in_acc   = in_valid_i & ~in_stall_o;
  assign out_load = (state_q == S_DONE) & (~out_valid_q | ~out_stall_i);

  dlts_mem #(
    .Width (EntW),
    .Depth (Slots)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    code_d       = code_q;
    delay_d      = delay_q;
    period_d     = period_q;
    target_d     = target_q;
    k_d          = k_q;
    j_d          = j_q;
    cnt_d        = cnt_q;
    sum_d        = sum_q;
    gap_d        = gap_q;
    id_d         = id_q;
    redo_d       = redo_q;
    cur_d        = cur_q;
    res_status_d = res_status_q;
    res_aid_d    = res_aid_q;
    res_code_d   = res_code_q;
    res_run_d    = res_run_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = rd_ent;
    mem_re       = 1'b0;
    mem_raddr    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_d        = command_i;
          code_d       = task_code_i;
          delay_d      = start_delay_i;
          period_d     = repeat_period_i;
          target_d     = target_id_i;
          k_d          = '0;
          sum_d        = '0;
          redo_d       = 1'b0;
          res_status_d = ST_OK;
          res_aid_d    = '0;
          res_code_d   = '0;
          res_run_d    = 1'b0;
          unique case (command_i)
            CMD_TICK, CMD_DISPATCH: begin
              if (cnt_q == '0) begin
                if (command_i == CMD_DISPATCH) begin
                  res_status_d = ST_NOT_READY;
                end
                state_d = S_DONE;
              end else begin
                mem_re  = 1'b1;
                state_d = S_HEAD;
              end
            end
            CMD_ADD:    state_d = S_INS_RD;
            CMD_DELETE: state_d = S_DEL_RD;
            default:    state_d = S_DONE;
          endcase
        end
      end
      S_HEAD: begin
        if (cmd_q == CMD_TICK) begin
          if (!rd_ent.ready) begin
            mem_we          = 1'b1;
            mem_wdata.rel   = tick_rel;
            mem_wdata.ready = (tick_rel == '0);
          end
          state_d = S_DONE;
        end else if (!rd_ent.ready) begin
          res_status_d = ST_NOT_READY;
          state_d      = S_DONE;
        end else begin
          res_code_d = rd_ent.code;
          res_run_d  = 1'b1;
          code_d     = rd_ent.code;
          delay_d    = rd_ent.period;
          period_d   = rd_ent.period;
          redo_d     = (rd_ent.period != '0);
          gap_d      = rd_ent.rel;
          k_d        = '0;
          j_d        = CntW'(1);
          state_d    = S_DN_RD;
        end
      end
      S_INS_RD: begin
        if (k_q == cnt_q) begin
          if (k_q == CntW'(Slots)) begin
            res_status_d = ST_FULL;
            res_aid_d    = '0;
            state_d      = S_DONE;
          end else begin
            state_d = S_INS_NEW;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = k_q[IdxW-1:0];
          state_d   = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        if (sum_ext <= {1'b0, delay_q}) begin
          sum_d   = sum_ext[DELAY_W-1:0];
          k_d     = k_q + 1'b1;
          state_d = S_INS_RD;
        end else begin
          cur_d     = rd_ent;
          cur_d.rel = sum_ext[DELAY_W-1:0] - delay_q;
          j_d       = (cnt_q == CntW'(Slots)) ? CntW'(Slots - 2) : cnt_q - 1'b1;
          state_d   = S_UP_RD;
        end
      end
      S_UP_RD: begin
        if (j_q > k_q) begin
          mem_re    = 1'b1;
          mem_raddr = j_q[IdxW-1:0];
          state_d   = S_UP_WR;
        end else begin
          state_d = S_INS_PUT;
        end
      end
      S_UP_WR: begin
        mem_we    = 1'b1;
        mem_waddr = IdxW'(j_q + 1'b1);
        mem_wdata = rd_ent;
        j_d       = j_q - 1'b1;
        state_d   = S_UP_RD;
      end
      S_INS_PUT: begin
        if (k_q != CntW'(Slots - 1)) begin
          mem_we    = 1'b1;
          mem_waddr = IdxW'(k_q + 1'b1);
          mem_wdata = cur_q;
        end
        state_d = S_INS_NEW;
      end
      S_INS_NEW: begin
        mem_we          = 1'b1;
        mem_waddr       = k_q[IdxW-1:0];
        mem_wdata.ready = (new_rel == '0);
        mem_wdata.code  = code_q;
        mem_wdata.rel   = new_rel;
        mem_wdata.period = period_q;
        mem_wdata.ident = id_next;
        id_d            = id_next;
        res_aid_d       = AID_W'(id_next);
        if (cnt_q != CntW'(Slots)) begin
          cnt_d = cnt_q + 1'b1;
        end
        state_d = S_DONE;
      end
      S_DEL_RD: begin
        if (k_q == cnt_q) begin
          res_status_d = ST_NOT_FOUND;
          state_d      = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = k_q[IdxW-1:0];
          state_d   = S_DEL_CHK;
        end
      end
      S_DEL_CHK: begin
        if (CmpW'(rd_ent.ident) == CmpW'(target_q)) begin
          gap_d   = rd_ent.rel;
          j_d     = k_q + 1'b1;
          state_d = S_DN_RD;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_DEL_RD;
        end
      end
      S_DN_RD: begin
        if (j_q < cnt_q) begin
          mem_re    = 1'b1;
          mem_raddr = j_q[IdxW-1:0];
          state_d   = S_DN_WR;
        end else begin
          cnt_d = cnt_q - 1'b1;
          if (redo_q) begin
            k_d     = '0;
            sum_d   = '0;
            state_d = S_INS_RD;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_DN_WR: begin
        mem_we        = 1'b1;
        mem_waddr     = IdxW'(j_q - 1'b1);
        mem_wdata     = rd_ent;
        mem_wdata.rel = rd_ent.rel + gap_q;
        gap_d         = '0;
        j_d           = j_q + 1'b1;
        state_d       = S_DN_RD;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      id_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      id_q        <= id_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    code_q       <= code_d;
    delay_q      <= delay_d;
    period_q     <= period_d;
    target_q     <= target_d;
    k_q          <= k_d;
    j_q          <= j_d;
    sum_q        <= sum_d;
    gap_q        <= gap_d;
    redo_q       <= redo_d;
    cur_q        <= cur_d;
    res_status_q <= res_status_d;
    res_aid_q    <= res_aid_d;
    res_code_q   <= res_code_d;
    res_run_q    <= res_run_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_aid_q    <= res_aid_q;
      out_code_q   <= res_code_q;
      out_run_q    <= res_run_q;
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign assigned_id_o = out_aid_q;
  assign run_code_o    = out_code_q;
  assign run_valid_o   = out_run_q;

endmodule
`default_nettype wire

// File: rtl/dlts_checker.sv
`default_nettype none
module dlts_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic [dlts_pkg::STATUS_W-1:0] status_o,
  input wire logic [dlts_pkg::AID_W-1:0]    assigned_id_o,
  input wire logic [dlts_pkg::CODE_W-1:0]   run_code_o,
  input wire logic                          run_valid_o
);
  import dlts_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(assigned_id_o)
      && $stable(run_code_o) && $stable(run_valid_o))
    else $error("stalled result changed");

  a_run_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && run_valid_o |-> status_o == ST_OK)
    else $error("dispatch with bad status");

  a_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_valid_o |-> run_code_o == '0)
    else $error("run code without dispatch");

  a_fail_no_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL || status_o == ST_NOT_FOUND
      || status_o == ST_NOT_READY) |-> assigned_id_o == '0 && !run_valid_o)
    else $error("failed request carries id or task");

endmodule

bind delta_list_task_scheduler dlts_checker u_dlts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .assigned_id_o (assigned_id_o),
  .run_code_o    (run_code_o),
  .run_valid_o   (run_valid_o)
);
`default_nettype wire

// File: tb/tb.sv
`default_nettype none
module tb;
  import dlts_pkg::*;

  localparam int NSLOT = 16;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [CODE_W-1:0]  code;
    logic [DELAY_W-1:0] delay;
    logic [DELAY_W-1:0] period;
    logic [TGT_W-1:0]   target;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [AID_W-1:0]    aid;
    logic [CODE_W-1:0]   rcode;
    logic                rvalid;
  } reply_t;

  typedef struct {
    bit         used;
    bit [7:0]   code;
    bit [31:0]  rel;
    bit [31:0]  period;
    bit         ready;
    bit [15:0]  ident;
  } task_entry_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic out_stall = 1;
  logic in_stall, out_valid;
  logic [CMD_W-1:0] command = CMD_TICK;
  logic [CODE_W-1:0] task_code = '0;
  logic [DELAY_W-1:0] start_delay = '0, repeat_period = '0;
  logic [TGT_W-1:0] target_id = '0;
  logic [STATUS_W-1:0] status;
  logic [AID_W-1:0] assigned_id;
  logic [CODE_W-1:0] run_code;
  logic run_valid;

  delta_list_task_scheduler u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .command_i(command), .task_code_i(task_code), .start_delay_i(start_delay),
    .repeat_period_i(repeat_period), .target_id_i(target_id),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .assigned_id_o(assigned_id),
    .run_code_o(run_code), .run_valid_o(run_valid)
  );

  always #5 clk = ~clk;

  task_entry_t sched [NSLOT];
  bit [15:0] id_seq;
  request_t pending_q[$];
  reply_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  int hold_off = 0;
  int long_hold = 0;
  bit long_hold_go = 0;
  bit long_hold_done = 0;
  int pause_sender = 0;
  bit stim_done = 0;
  bit [15:0] live_ids[$];

  function automatic bit [15:0] take_id();
    id_seq = id_seq + 16'd1;
    if (id_seq == 0) id_seq = 1;
    return id_seq;
  endfunction

  function automatic bit [15:0] sched_insert(bit [7:0] code, bit [31:0] dly, bit [31:0] per);
    longint unsigned sum, prior;
    bit [31:0] nd;
    sum = 0;
    for (int k = 0; k < NSLOT; k++) begin
      prior = sum;
      if (sched[k].used) begin
        sum += sched[k].rel;
        if (sum <= dly) continue;
        sched[k].rel = 32'(sum - dly);
        for (int j = NSLOT - 1; j > k; j--) sched[j] = sched[j-1];
      end
      nd = 32'(longint'(dly) - prior);
      sched[k].used = 1;
      sched[k].code = code;
      sched[k].rel = nd;
      sched[k].period = per;
      sched[k].ready = (nd == 0);
      sched[k].ident = take_id();
      return sched[k].ident;
    end
    return 0;
  endfunction

  function automatic void sched_remove(int k);
    if (k + 1 < NSLOT && sched[k+1].used) sched[k+1].rel += sched[k].rel;
    for (int j = k; j < NSLOT - 1; j++) sched[j] = sched[j+1];
    sched[NSLOT-1] = '{default: 0};
  endfunction

  function automatic reply_t predict_reply(request_t r);
    reply_t y;
    task_entry_t head;
    y = '0;
    y.status = ST_OK;
    case (r.cmd)
      CMD_TICK: begin
        if (sched[0].used && !sched[0].ready) begin
          if (sched[0].rel > 0) sched[0].rel--;
          if (sched[0].rel == 0) sched[0].ready = 1;
        end
      end
      CMD_ADD: begin
        y.aid = sched_insert(r.code, r.delay, r.period);
        if (y.aid == 0) y.status = ST_FULL;
      end
      CMD_DELETE: begin
        y.status = ST_NOT_FOUND;
        for (int k = 0; k < NSLOT; k++) begin
          if (sched[k].used && sched[k].ident == r.target) begin
            sched_remove(k);
            y.status = ST_OK;
            break;
          end
        end
      end
      default: begin
        if (sched[0].used && sched[0].ready) begin
          head = sched[0];
          y.rcode = head.code;
          y.rvalid = 1;
          sched_remove(0);
          if (head.period != 0) y.aid = sched_insert(head.code, head.period, head.period);
        end else begin
          y.status = ST_NOT_READY;
        end
      end
    endcase
    return y;
  endfunction

  function automatic request_t make_req(bit [1:0] c, bit [7:0] code, bit [31:0] d,
                                        bit [31:0] p, bit [15:0] t);
    request_t r;
    r.cmd = c; r.code = code; r.delay = d; r.period = p; r.target = t;
    return r;
  endfunction

  function automatic int gap_len();
    int v;
    v = $urandom_range(0, 99);
    if (v < 50) return 0;
    if (v < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic bit [31:0] rand_delay();
    int v;
    v = $urandom_range(0, 9);
    if (v < 6) return $urandom_range(0, 8);
    if (v < 8) return $urandom_range(0, 40);
    if (v < 9) return 32'hFFFF_FFFF - $urandom_range(0, 3);
    return $urandom;
  endfunction

  function automatic request_t rand_req();
    int v;
    bit [15:0] t;
    v = $urandom_range(0, 99);
    if (v < 40) return make_req(CMD_TICK, 8'($urandom), $urandom, $urandom, 16'($urandom));
    if (v < 65) return make_req(CMD_ADD, 8'($urandom), rand_delay(),
                                ($urandom_range(0, 2) == 0) ? 32'd0 : rand_delay(),
                                16'($urandom));
    if (v < 78) begin
      if (live_ids.size() > 0 && $urandom_range(0, 3) != 0)
        t = live_ids[$urandom_range(0, live_ids.size() - 1)];
      else
        t = 16'($urandom);
      return make_req(CMD_DELETE, 8'($urandom), $urandom, $urandom, t);
    end
    return make_req(CMD_DISPATCH, 8'($urandom), $urandom, $urandom, 16'($urandom));
  endfunction

  // driver
  int gap = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (in_valid && !in_stall) begin
      expected_q.push_back(predict_reply(make_req(command, task_code, start_delay,
                                                  repeat_period, target_id)));
      if (command == CMD_ADD && expected_q[$].aid != 0)
        live_ids.push_back(expected_q[$].aid);
    end
    if (!in_valid || !in_stall) begin
      if (gap > 0) begin
        gap <= gap - 1;
        in_valid <= 0;
      end else if (pause_sender > 0 && (in_valid && !in_stall || expected_q.size() > 0)) begin
        in_valid <= 0;
      end else if (pending_q.size() > 0) begin
        request_t r;
        r = pending_q.pop_front();
        if (pause_sender > 0) pause_sender <= pause_sender - 1;
        in_valid <= 1;
        command <= r.cmd;
        task_code <= r.code;
        start_delay <= r.delay;
        repeat_period <= r.period;
        target_id <= r.target;
        gap <= gap_len();
      end else begin
        in_valid <= 0;
      end
    end
  end

  // long receiver hold
  always @(posedge clk) begin
    if (long_hold_go && !long_hold_done) begin
      long_hold <= 300;
      long_hold_done <= 1;
    end else if (long_hold > 0) begin
      long_hold <= long_hold - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      reply_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected reply status=%0d aid=%0d code=%0d rv=%0d",
                 $time, status, assigned_id, run_code, run_valid);
        errors <= errors + 1;
      end else begin
        e = expected_q.pop_front();
        if ({status, assigned_id, run_code, run_valid} !== e) begin
          $display("%0t: mismatch expected status=%0d aid=%0d code=%0d rv=%0d",
                   $time, e.status, e.aid, e.rcode, e.rvalid);
          $display("%0t:          actual   status=%0d aid=%0d code=%0d rv=%0d",
                   $time, status, assigned_id, run_code, run_valid);
          errors <= errors + 1;
        end
      end
    end
    if (!rst_n) out_stall <= 1;
    else if (long_hold > 0) out_stall <= 1;
    else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1;
    end else if ($urandom_range(0, 99) < 8) begin
      hold_off <= gap_len();
      out_stall <= 1;
    end else out_stall <= 0;
  end

  always @(posedge clk) begin
    if (cycles >= LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < NSLOT; k++) sched[k] = '{default: 0};
    id_seq = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    // directed: empty cases
    pending_q.push_back(make_req(CMD_TICK, 0, 0, 0, 0));
    pending_q.push_back(make_req(CMD_DISPATCH, 8'hFF, '1, '1, '1));
    pending_q.push_back(make_req(CMD_DELETE, 0, 0, 0, 0));
    pending_q.push_back(make_req(CMD_DELETE, 0, 0, 0, 16'hFFFF));
    // zero delay is ready at once, periodic re-add
    pending_q.push_back(make_req(CMD_ADD, 8'hA5, 0, 2, 0));
    pending_q.push_back(make_req(CMD_ADD, 8'h5A, 0, 0, 16'hFFFF));
    pending_q.push_back(make_req(CMD_DISPATCH, 0, 0, 0, 0));
    pending_q.push_back(make_req(CMD_DISPATCH, 0, 0, 0, 0));
    pending_q.push_back(make_req(CMD_DISPATCH, 0, 0, 0, 0));
    pending_q.push_back(make_req(CMD_TICK, 0, 0, 0, 0));
    pending_q.push_back(make_req(CMD_TICK, 0, 0, 0, 0));
    pending_q.push_back(make_req(CMD_DISPATCH, 0, 0, 0, 0));
    // delete of a stale id, then of the last entry
    pending_q.push_back(make_req(CMD_DELETE, 0, 0, 0, 16'd3));
    pending_q.push_back(make_req(CMD_ADD, 8'h01, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
    pending_q.push_back(make_req(CMD_ADD, 8'h02, 5, 0, 0));
    pending_q.push_back(make_req(CMD_ADD, 8'h03, 5, 0, 0));
    pending_q.push_back(make_req(CMD_DELETE, 0, 0, 0, 16'd5));
    // fill the table, then overflow both ways
    for (int i = 0; i < 15; i++)
      pending_q.push_back(make_req(CMD_ADD, 8'(i), 32'(10 + i), 0, 0));
    pending_q.push_back(make_req(CMD_ADD, 8'hEE, 32'hFFFF_FFFF, 0, 0));
    pending_q.push_back(make_req(CMD_ADD, 8'hDD, 1, 0, 0));
    // long receiver hold while sender keeps going
    wait (pending_q.size() == 0);
    long_hold_go = 1;
    for (int i = 0; i < 40; i++) pending_q.push_back(rand_req());
    wait (pending_q.size() == 0);
    pause_sender <= 1;
    for (int i = 0; i < 400; i++) begin
      pending_q.push_back(rand_req());
      if (i % 100 == 50) wait (pending_q.size() < 20);
      // purge table now and then
      if (i % 120 == 119)
        for (int j = 0; j < 20; j++)
          pending_q.push_back(make_req(($urandom_range(0, 1) != 0) ? CMD_TICK : CMD_DISPATCH,
                                       0, 0, 0, 0));
    end
    wait (pending_q.size() == 0 && !in_valid && expected_q.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end
endmodule
`default_nettype wire
